// File: rtl/qlu_pkg.sv
// Shared constants and helpers for the hashed Q-learning update engine.
`default_nettype none
package qlu_pkg;
    localparam int MAX_STATES   = 1024;
    localparam int HASH_BUCKETS = 1024;
    localparam int NUM_ACTIONS  = 4;
    localparam int STATE_DIMS   = 4;
    localparam int IDX_W        = $clog2(MAX_STATES);
    localparam int PTR_W        = IDX_W + 1;
    localparam int BKT_W        = $clog2(HASH_BUCKETS);
    localparam int ACT_W        = $clog2(NUM_ACTIONS);
    localparam int KEY_W        = 12;
    localparam int KEYS_W       = KEY_W * STATE_DIMS;
    localparam int QADDR_W      = IDX_W + ACT_W;
    localparam int MUL_A_W      = 35;
    localparam int MUL_P_W      = MUL_A_W + 17;

    localparam logic [31:0] FNV_BASIS    = 32'd2166136261;
    localparam logic [15:0] ALPHA_RESET  = 16'd6554;
    localparam logic [15:0] GAMMA_RESET  = 16'd64881;
    localparam logic [7:0]  REG_ALPHA    = 8'd0;
    localparam logic [7:0]  REG_GAMMA    = 8'd1;

    function automatic logic signed [KEY_W-1:0] quantize(input logic signed [15:0] s);
        logic [15:0] mag;
        logic [19:0] prod;
        logic [10:0] k;
        mag  = s[15] ? (~s + 16'd1) : s;
        prod = {4'b0, mag} * 20'd10 + 20'd128;
        k    = prod[18:8];
        return s[15] ? -$signed({1'b0, k}) : $signed({1'b0, k});
    endfunction

    // FNV-1a step: xor then multiply by 16777619 = 2^24 + 403
    function automatic logic [31:0] fnv_step(input logic [31:0] h,
                                             input logic signed [KEY_W-1:0] k);
        logic [31:0] x;
        x = h ^ {{(32-KEY_W){k[KEY_W-1]}}, k};
        return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
    endfunction
endpackage
`default_nettype wire

// File: rtl/hashed_q_learning_update.sv
// Top level: hashed Q-table engine with lookup sequencer and TD update.
//
//  channel | dir | handshake           | payload
//  s_axis  | in  | i_s_axis_tvalid/o_.. | tdata: states, action, reward; tuser cmd; tlast done
//  m_axis  | out | o_m_axis_tvalid/i_.. | tdata: action, q_result, table_full, stored_states
//  cfg     | in  | i_cfg_valid/o_cfg_.. | index, 16-bit data
//
// Per lookup: the keys are hashed one dimension at a time, the bucket head is read, each
// chain entry is read and compared, and on a miss the chain end is reached and a row is
// inserted and zeroed; then the result is dispatched. Act adds a max scan; learn runs two
// lookups, the max scan (skipped when done) and the multiply and update steps.
// After reset all bucket heads are cleared; no beat is taken.
// A finished result waits in the output register while the master stalls.
`default_nettype none
module hashed_q_learning_update (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // cur_state_0..3 [63:0], nxt_state_0..3 [127:64], taken_action [129:128],
    // reward_value [161:130], zero fill [167:162]
    input  wire logic [167:0] i_s_axis_tdata,
    // cmd
    input  wire logic         i_s_axis_tuser,
    input  wire logic         i_s_axis_tlast,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // chosen_action [1:0], q_result [33:2], table_full [34], stored_states [45:35],
    // zero fill [47:46]
    output logic      [47:0]  o_m_axis_tdata,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [15:0]  i_cfg_data
);
    localparam int IW = qlu_pkg::IDX_W;
    localparam int PW = qlu_pkg::PTR_W;
    localparam int BW = qlu_pkg::BKT_W;
    localparam int AW = qlu_pkg::ACT_W;
    localparam int KW = qlu_pkg::KEY_W;
    localparam int KSW = qlu_pkg::KEYS_W;
    localparam int QW = qlu_pkg::QADDR_W;
    localparam int MW = qlu_pkg::MUL_A_W;
    localparam int PRW = qlu_pkg::MUL_P_W;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_HASH, ST_HEAD_RD, ST_HEAD_WT, ST_WALK_RD, ST_WALK_CMP,
        ST_INSERT, ST_ZERO, ST_FETCHED, ST_MAX, ST_CUR_RD, ST_CUR_WT, ST_MUL_G,
        ST_DIFF, ST_MUL_A, ST_UPD, ST_FIN
    } t_state;

    t_state                 r_state;
    logic [BW-1:0]          r_clr;
    logic [PW-1:0]          r_count;
    logic [15:0]            r_alpha;
    logic [15:0]            r_gamma;
    logic                   r_cmd;
    logic                   r_done;
    logic [AW-1:0]          r_ta;
    logic signed [31:0]     r_reward;
    logic [KSW-1:0]         r_key;
    logic [KSW-1:0]         r_nkey;
    logic [31:0]            r_hash;
    logic [AW:0]            r_j;
    logic [PW-1:0]          r_p;
    logic [PW-1:0]          r_head;
    logic [IW-1:0]          r_idx;
    logic [IW-1:0]          r_ci;
    logic                   r_ok;
    logic                   r_ok1;
    logic                   r_sel;
    logic signed [31:0]     r_best;
    logic [AW-1:0]          r_bidx;
    logic signed [31:0]     r_cur;
    logic signed [MW-1:0]   r_diff;
    logic [AW-1:0]          r_act;
    logic signed [31:0]     r_q;
    logic                   r_full;
    logic                   r_ovalid;
    logic [47:0]            r_odata;

    logic                   bh_we;
    logic [BW-1:0]          bh_waddr;
    logic [PW-1:0]          bh_wdata;
    logic [PW-1:0]          bh_rdata;
    logic [IW-1:0]          kl_raddr;
    logic [KSW-1:0]         key_rdata;
    logic [PW-1:0]          link_rdata;
    logic                   kl_we;
    logic                   q_we;
    logic [QW-1:0]          q_waddr;
    logic [31:0]            q_wdata;
    logic [QW-1:0]          q_raddr;
    logic [31:0]            q_rdata;
    logic signed [MW-1:0]   mul_a;
    logic [15:0]            mul_b;
    logic signed [PRW-1:0]  mul_p;
    logic signed [PRW-1:0]  prod_rnd;
    logic                   take;
    logic signed [31:0]     best_nx;
    logic [AW-1:0]          bidx_nx;
    logic signed [36:0]     nq;
    logic signed [31:0]     nq_sat;
    logic                   accept;
    logic [KSW-1:0]         ckey_in;
    logic [KSW-1:0]         nkey_in;
    logic [AW-1:0]          jm1;

    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    always_comb begin
        for (int d = 0; d < qlu_pkg::STATE_DIMS; d++) begin
            ckey_in[d*KW +: KW] = qlu_pkg::quantize($signed(i_s_axis_tdata[d*16 +: 16]));
            nkey_in[d*KW +: KW] = qlu_pkg::quantize($signed(i_s_axis_tdata[64 + d*16 +: 16]));
        end
    end

    assign jm1 = AW'(r_j - 1'b1);

    assign bh_we    = (r_state == ST_CLEAR) || (r_state == ST_INSERT);
    assign bh_waddr = (r_state == ST_CLEAR) ? r_clr : r_hash[BW-1:0];
    assign bh_wdata = (r_state == ST_CLEAR) ? '0 : PW'(r_count + 1'b1);
    assign kl_raddr = IW'(r_p - 1'b1);
    assign kl_we    = (r_state == ST_INSERT);

    assign q_raddr  = (r_state == ST_MAX) ? {r_idx, r_j[AW-1:0]} : {r_ci, r_ta};
    assign q_we     = (r_state == ST_ZERO) || (r_state == ST_UPD);
    assign q_waddr  = (r_state == ST_ZERO) ? {r_idx, r_j[AW-1:0]} : {r_ci, r_ta};
    assign q_wdata  = (r_state == ST_ZERO) ? 32'd0 : nq_sat;

    assign mul_a    = (r_state == ST_MUL_A) ? r_diff : MW'(r_best);
    assign mul_b    = (r_state == ST_MUL_A) ? r_alpha : r_gamma;
    assign prod_rnd = (mul_p + PRW'(32768)) >>> 16;

    assign take    = (r_j == 1) || ($signed(q_rdata) > r_best);
    assign best_nx = take ? $signed(q_rdata) : r_best;
    assign bidx_nx = take ? jm1 : r_bidx;

    always_comb begin
        nq = 37'(r_cur) + 37'(prod_rnd);
        if (nq > 37'sd2147483647) begin
            nq_sat = 32'sh7FFFFFFF;
        end else if (nq < -37'sd2147483648) begin
            nq_sat = 32'sh80000000;
        end else begin
            nq_sat = nq[31:0];
        end
    end

    qlu_ram #(.W(PW), .DEPTH(qlu_pkg::HASH_BUCKETS)) u_bucket_head (
        .i_clk(i_clk), .i_we(bh_we), .i_waddr(bh_waddr), .i_wdata(bh_wdata),
        .i_raddr(r_hash[BW-1:0]), .o_rdata(bh_rdata)
    );

    qlu_ram #(.W(KSW), .DEPTH(qlu_pkg::MAX_STATES)) u_key_store (
        .i_clk(i_clk), .i_we(kl_we), .i_waddr(r_count[IW-1:0]), .i_wdata(r_key),
        .i_raddr(kl_raddr), .o_rdata(key_rdata)
    );

    qlu_ram #(.W(PW), .DEPTH(qlu_pkg::MAX_STATES)) u_chain_link (
        .i_clk(i_clk), .i_we(kl_we), .i_waddr(r_count[IW-1:0]), .i_wdata(r_head),
        .i_raddr(kl_raddr), .o_rdata(link_rdata)
    );

    qlu_ram #(.W(32), .DEPTH(qlu_pkg::MAX_STATES * qlu_pkg::NUM_ACTIONS)) u_qvalue_store (
        .i_clk(i_clk), .i_we(q_we), .i_waddr(q_waddr), .i_wdata(q_wdata),
        .i_raddr(q_raddr), .o_rdata(q_rdata)
    );

    qlu_mul u_mul (.i_clk(i_clk), .i_a(mul_a), .i_b(mul_b), .o_p(mul_p));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_clr    <= '0;
            r_count  <= '0;
            r_alpha  <= qlu_pkg::ALPHA_RESET;
            r_gamma  <= qlu_pkg::GAMMA_RESET;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                if (i_cfg_index == qlu_pkg::REG_ALPHA) begin
                    r_alpha <= i_cfg_data;
                end else if (i_cfg_index == qlu_pkg::REG_GAMMA) begin
                    r_gamma <= i_cfg_data;
                end
            end
            if (r_ovalid && i_m_axis_tready && (r_state != ST_FIN)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_clr <= BW'(r_clr + 1'b1);
                    if (r_clr == {BW{1'b1}}) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd    <= i_s_axis_tuser;
                        r_done   <= i_s_axis_tlast;
                        r_ta     <= i_s_axis_tdata[129:128];
                        r_reward <= $signed(i_s_axis_tdata[161:130]);
                        r_key    <= ckey_in;
                        r_nkey   <= nkey_in;
                        r_hash   <= qlu_pkg::FNV_BASIS;
                        r_j      <= '0;
                        r_sel    <= 1'b0;
                        r_act    <= i_s_axis_tuser ? i_s_axis_tdata[129:128] : '0;
                        r_q      <= '0;
                        r_full   <= 1'b0;
                        r_state  <= ST_HASH;
                    end
                end
                ST_HASH: begin
                    r_hash <= qlu_pkg::fnv_step(r_hash, $signed(r_key[r_j[1:0]*KW +: KW]));
                    r_j    <= (AW+1)'(r_j + 1'b1);
                    if (r_j == (AW+1)'(qlu_pkg::STATE_DIMS - 1)) begin
                        r_state <= ST_HEAD_RD;
                    end
                end
                ST_HEAD_RD: begin
                    r_state <= ST_HEAD_WT;
                end
                ST_HEAD_WT: begin
                    r_p     <= bh_rdata;
                    r_head  <= bh_rdata;
                    r_state <= ST_WALK_RD;
                end
                ST_WALK_RD: begin
                    if (r_p != '0) begin
                        r_state <= ST_WALK_CMP;
                    end else if (r_count >= PW'(qlu_pkg::MAX_STATES)) begin
                        r_ok    <= 1'b0;
                        r_state <= ST_FETCHED;
                    end else begin
                        r_state <= ST_INSERT;
                    end
                end
                ST_WALK_CMP: begin
                    if (key_rdata == r_key) begin
                        r_idx   <= kl_raddr;
                        r_ok    <= 1'b1;
                        r_state <= ST_FETCHED;
                    end else begin
                        r_p     <= link_rdata;
                        r_state <= ST_WALK_RD;
                    end
                end
                ST_INSERT: begin
                    r_idx   <= r_count[IW-1:0];
                    r_count <= PW'(r_count + 1'b1);
                    r_j     <= '0;
                    r_state <= ST_ZERO;
                end
                ST_ZERO: begin
                    r_j <= (AW+1)'(r_j + 1'b1);
                    if (r_j == (AW+1)'(qlu_pkg::NUM_ACTIONS - 1)) begin
                        r_ok    <= 1'b1;
                        r_state <= ST_FETCHED;
                    end
                end
                ST_FETCHED: begin
                    r_j <= '0;
                    if (!r_cmd) begin
                        if (r_ok) begin
                            r_state <= ST_MAX;
                        end else begin
                            r_full  <= 1'b1;
                            r_state <= ST_FIN;
                        end
                    end else if (!r_sel) begin
                        r_ok1   <= r_ok;
                        r_ci    <= r_idx;
                        r_sel   <= 1'b1;
                        r_key   <= r_nkey;
                        r_hash  <= qlu_pkg::FNV_BASIS;
                        r_state <= ST_HASH;
                    end else if (!(r_ok1 && r_ok)) begin
                        r_full  <= 1'b1;
                        r_state <= ST_FIN;
                    end else if ({1'b0, r_ta} >= (AW+1)'(qlu_pkg::NUM_ACTIONS)) begin
                        r_state <= ST_FIN;
                    end else if (!r_done) begin
                        r_state <= ST_MAX;
                    end else begin
                        r_state <= ST_CUR_RD;
                    end
                end
                ST_MAX: begin
                    r_j <= (AW+1)'(r_j + 1'b1);
                    if (r_j != '0) begin
                        r_best <= best_nx;
                        r_bidx <= bidx_nx;
                    end
                    if (r_j == (AW+1)'(qlu_pkg::NUM_ACTIONS)) begin
                        if (!r_cmd) begin
                            r_act   <= bidx_nx;
                            r_q     <= best_nx;
                            r_state <= ST_FIN;
                        end else begin
                            r_state <= ST_CUR_RD;
                        end
                    end
                end
                ST_CUR_RD: begin
                    r_state <= ST_CUR_WT;
                end
                ST_CUR_WT: begin
                    r_cur   <= $signed(q_rdata);
                    r_state <= r_done ? ST_DIFF : ST_MUL_G;
                end
                ST_MUL_G: begin
                    r_state <= ST_DIFF;
                end
                ST_DIFF: begin
                    r_diff  <= MW'(r_reward) - MW'(r_cur)
                               + (r_done ? MW'(0) : MW'(prod_rnd));
                    r_state <= ST_MUL_A;
                end
                ST_MUL_A: begin
                    r_state <= ST_UPD;
                end
                ST_UPD: begin
                    r_q     <= nq_sat;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        r_odata  <= {2'b00, r_count, r_full, r_q, r_act};
                        r_state  <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/qlu_ram.sv
// Generic single write, single read RAM with registered read data.
`default_nettype none
module qlu_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [W-1:0]  i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [W-1:0]  o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: rtl/qlu_mul.sv
// Shared signed-by-fraction multiplier with registered product.
`default_nettype none
module qlu_mul (
    input  wire logic                                 i_clk,
    input  wire logic signed [qlu_pkg::MUL_A_W-1:0]   i_a,
    input  wire logic        [15:0]                   i_b,
    output logic      signed [qlu_pkg::MUL_P_W-1:0]   o_p
);
    always_ff @(posedge i_clk) begin
        o_p <= qlu_pkg::MUL_P_W'(i_a * $signed({1'b0, i_b}));
    end
endmodule
`default_nettype wire
